### src/psrt_pkg.sv
// Shared types, widths, register indexes and the saturation helper for the
// point scale/rotate/translate pipeline. No dependencies.
`default_nettype none

package psrt_pkg;

    localparam int unsigned COORD_W = 32;   // Q16.16 coordinate
    localparam int unsigned COEF_W  = 16;   // Q8.8 scale or Q2.14 trig
    localparam int unsigned SCALE_W = 48;   // packed scale register
    localparam int unsigned ROT_W   = 32;   // packed cos/sin register
    localparam int unsigned CFG_W   = 48;   // config write data
    localparam int unsigned IDX_W   = 3;    // config index
    localparam int unsigned PROD_W  = COORD_W + COEF_W;

    localparam int unsigned SCALE_FRAC = 8;
    localparam int unsigned ROT_FRAC   = 14;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_SCALE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROT_X   = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROT_Y   = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROT_Z   = 3'd3;
    localparam logic [IDX_W-1:0] REG_SHIFT_X = 3'd4;
    localparam logic [IDX_W-1:0] REG_SHIFT_Y = 3'd5;
    localparam logic [IDX_W-1:0] REG_SHIFT_Z = 3'd6;

    localparam logic [SCALE_W-1:0] SCALE_RST = 48'h0100_0100_0100;
    localparam logic [ROT_W-1:0]   ROT_RST   = 32'h4000_0000;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    // Pipeline control that travels with each request
    typedef struct packed {
        logic vld;
        logic clip;
    } t_ctl;

    typedef struct packed {
        logic [COORD_W-1:0] val;
        logic               clip;
    } t_sat;

    function automatic t_sat sat32(input logic signed [63:0] v);
        t_sat r;
        if (v > SAT_MAX) begin
            r.val  = SAT_MAX[COORD_W-1:0];
            r.clip = 1'b1;
        end else if (v < SAT_MIN) begin
            r.val  = SAT_MIN[COORD_W-1:0];
            r.clip = 1'b1;
        end else begin
            r.val  = v[COORD_W-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/psrt_scale.sv
// Per-axis Q8.8 scale: multiply stage, then round/saturate stage.
// Depends on psrt_pkg.
`default_nettype none

module psrt_scale (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire psrt_pkg::t_ctl                      i_ctl,
    input  wire logic signed [psrt_pkg::COORD_W-1:0] i_x,
    input  wire logic signed [psrt_pkg::COORD_W-1:0] i_y,
    input  wire logic signed [psrt_pkg::COORD_W-1:0] i_z,
    input  wire logic [psrt_pkg::SCALE_W-1:0]        i_scale,
    output psrt_pkg::t_ctl                           o_ctl,
    output logic signed [psrt_pkg::COORD_W-1:0]      o_x,
    output logic signed [psrt_pkg::COORD_W-1:0]      o_y,
    output logic signed [psrt_pkg::COORD_W-1:0]      o_z
);

    psrt_pkg::t_ctl r_ctl_m, r_ctl_s;
    logic signed [psrt_pkg::PROD_W-1:0]  r_prod [3];
    logic signed [psrt_pkg::COORD_W-1:0] r_res  [3];
    logic signed [psrt_pkg::COORD_W-1:0] w_in   [3];
    logic signed [psrt_pkg::COEF_W-1:0]  w_sc   [3];
    logic signed [psrt_pkg::PROD_W:0]    w_rnd  [3];
    psrt_pkg::t_sat                      w_sat  [3];
    logic signed [psrt_pkg::COORD_W-1:0] n_res  [3];
    logic                                n_clip;

    assign w_in[0] = i_x;
    assign w_in[1] = i_y;
    assign w_in[2] = i_z;
    assign w_sc[0] = $signed(i_scale[47:32]);
    assign w_sc[1] = $signed(i_scale[31:16]);
    assign w_sc[2] = $signed(i_scale[15:0]);

    // round half up, then back to Q16.16
    always_comb begin
        n_clip = r_ctl_m.clip;
        for (int i = 0; i < 3; i++) begin
            w_rnd[i] = (($bits(w_rnd[i]))'(r_prod[i])
                        + (($bits(w_rnd[i]))'(1) <<< (psrt_pkg::SCALE_FRAC - 1)))
                       >>> psrt_pkg::SCALE_FRAC;
            w_sat[i] = psrt_pkg::sat32(64'(w_rnd[i]));
            n_res[i] = $signed(w_sat[i].val);
            n_clip   = n_clip | w_sat[i].clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_m <= '0;
            r_ctl_s <= '0;
        end else if (i_en) begin
            r_ctl_m <= i_ctl;
            r_ctl_s <= '{vld: r_ctl_m.vld, clip: n_clip};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= w_in[i] * w_sc[i];
                r_res[i]  <= n_res[i];
            end
        end
    end

    assign o_ctl = r_ctl_s;
    assign o_x   = r_res[0];
    assign o_y   = r_res[1];
    assign o_z   = r_res[2];

endmodule

`default_nettype wire

### src/psrt_rot.sv
// One plane rotation: a' = c*a - s*b, b' = s*a + c*b, p passes through.
// Products stage, then sum/round/saturate stage. Depends on psrt_pkg.
`default_nettype none

module psrt_rot (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire psrt_pkg::t_ctl                      i_ctl,
    input  wire logic signed [psrt_pkg::COORD_W-1:0] i_a,
    input  wire logic signed [psrt_pkg::COORD_W-1:0] i_b,
    input  wire logic signed [psrt_pkg::COORD_W-1:0] i_p,
    input  wire logic [psrt_pkg::ROT_W-1:0]          i_cs,
    output psrt_pkg::t_ctl                           o_ctl,
    output logic signed [psrt_pkg::COORD_W-1:0]      o_a,
    output logic signed [psrt_pkg::COORD_W-1:0]      o_b,
    output logic signed [psrt_pkg::COORD_W-1:0]      o_p
);

    localparam int unsigned SUM_W = psrt_pkg::PROD_W + 2;

    psrt_pkg::t_ctl r_ctl_m, r_ctl_s;
    logic signed [psrt_pkg::PROD_W-1:0]  r_ca, r_sb, r_sa, r_cb;
    logic signed [psrt_pkg::COORD_W-1:0] r_p_m, r_p_s, r_a, r_b;
    logic signed [psrt_pkg::COEF_W-1:0]  w_c, w_s;
    logic signed [SUM_W-1:0]             w_half, w_sum_a, w_sum_b;
    psrt_pkg::t_sat                      w_sat_a, w_sat_b;
    logic                                n_clip;

    assign w_c    = $signed(i_cs[31:16]);
    assign w_s    = $signed(i_cs[15:0]);
    assign w_half = SUM_W'(1) <<< (psrt_pkg::ROT_FRAC - 1);

    always_comb begin
        w_sum_a = (SUM_W'(r_ca) - SUM_W'(r_sb) + w_half) >>> psrt_pkg::ROT_FRAC;
        w_sum_b = (SUM_W'(r_sa) + SUM_W'(r_cb) + w_half) >>> psrt_pkg::ROT_FRAC;
        w_sat_a = psrt_pkg::sat32(64'(w_sum_a));
        w_sat_b = psrt_pkg::sat32(64'(w_sum_b));
        n_clip  = r_ctl_m.clip | w_sat_a.clip | w_sat_b.clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_m <= '0;
            r_ctl_s <= '0;
        end else if (i_en) begin
            r_ctl_m <= i_ctl;
            r_ctl_s <= '{vld: r_ctl_m.vld, clip: n_clip};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ca  <= i_a * w_c;
            r_sb  <= i_b * w_s;
            r_sa  <= i_a * w_s;
            r_cb  <= i_b * w_c;
            r_p_m <= i_p;
            r_a   <= $signed(w_sat_a.val);
            r_b   <= $signed(w_sat_b.val);
            r_p_s <= r_p_m;
        end
    end

    assign o_ctl = r_ctl_s;
    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_p   = r_p_s;

endmodule

`default_nettype wire

### src/psrt_xlate.sv
// Translation add with saturation; this stage is the output register.
// Depends on psrt_pkg.
`default_nettype none

module psrt_xlate (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire psrt_pkg::t_ctl                      i_ctl,
    input  wire logic signed [psrt_pkg::COORD_W-1:0] i_x,
    input  wire logic signed [psrt_pkg::COORD_W-1:0] i_y,
    input  wire logic signed [psrt_pkg::COORD_W-1:0] i_z,
    input  wire logic signed [psrt_pkg::COORD_W-1:0] i_tx,
    input  wire logic signed [psrt_pkg::COORD_W-1:0] i_ty,
    input  wire logic signed [psrt_pkg::COORD_W-1:0] i_tz,
    output psrt_pkg::t_ctl                           o_ctl,
    output logic signed [psrt_pkg::COORD_W-1:0]      o_x,
    output logic signed [psrt_pkg::COORD_W-1:0]      o_y,
    output logic signed [psrt_pkg::COORD_W-1:0]      o_z
);

    psrt_pkg::t_ctl r_ctl;
    logic signed [psrt_pkg::COORD_W-1:0] r_res [3];
    logic signed [psrt_pkg::COORD_W-1:0] w_pt  [3];
    logic signed [psrt_pkg::COORD_W-1:0] w_t   [3];
    logic signed [psrt_pkg::COORD_W:0]   w_sum [3];
    psrt_pkg::t_sat                      w_sat [3];
    logic                                n_clip;

    assign w_pt[0] = i_x;
    assign w_pt[1] = i_y;
    assign w_pt[2] = i_z;
    assign w_t[0]  = i_tx;
    assign w_t[1]  = i_ty;
    assign w_t[2]  = i_tz;

    always_comb begin
        n_clip = i_ctl.clip;
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = ($bits(w_sum[i]))'(w_pt[i]) + ($bits(w_sum[i]))'(w_t[i]);
            w_sat[i] = psrt_pkg::sat32(64'(w_sum[i]));
            n_clip   = n_clip | w_sat[i].clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= '{vld: i_ctl.vld, clip: n_clip};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_res[i] <= $signed(w_sat[i].val);
            end
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_res[0];
    assign o_y   = r_res[1];
    assign o_z   = r_res[2];

endmodule

`default_nettype wire

### src/point_scale_rotate_translate_unit.sv
// Top level of the point scale/rotate/translate pipeline: config registers,
// stall control and the stage chain. Depends on psrt_pkg, psrt_scale,
// psrt_rot and psrt_xlate.
`default_nettype none

// Transforms one signed Q16.16 point per request into Rz*Ry*Rx*S*p + t.
// Throughput is one request per clock while the output is not held. The
// stages from accept to the output register are the Q8.8 scale (multiply,
// round/saturate), the X, Y and Z rotations (products, sum/round/saturate
// each) and the translation add, which is also the output register. The
// scale and rotations round half up; every stage saturates to 32 bits and
// o_clipped is set if any stage clamped. The whole chain advances together:
// while a result sits unaccepted on the output, every stage holds and
// o_in_stall is raised, so nothing is lost or repeated. Configuration
// registers (index 0 scale_xyz 48 bits, 1..3 cos/sin per axis, 4..6 shifts)
// are written through i_cfg_we/i_cfg_idx/i_cfg_wdata; index 7 is ignored.
// Write them only while the pipeline is empty.

module point_scale_rotate_translate_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [psrt_pkg::IDX_W-1:0]          i_cfg_idx,
    input  wire logic [psrt_pkg::CFG_W-1:0]          i_cfg_wdata,
    // request in
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [psrt_pkg::COORD_W-1:0] i_x_in,
    input  wire logic signed [psrt_pkg::COORD_W-1:0] i_y_in,
    input  wire logic signed [psrt_pkg::COORD_W-1:0] i_z_in,
    // result out
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [psrt_pkg::COORD_W-1:0]      o_x_out,
    output logic signed [psrt_pkg::COORD_W-1:0]      o_y_out,
    output logic signed [psrt_pkg::COORD_W-1:0]      o_z_out,
    output logic                                     o_clipped
);

    // Config registers
    logic [psrt_pkg::SCALE_W-1:0]        r_scale;
    logic [psrt_pkg::ROT_W-1:0]          r_rot_x, r_rot_y, r_rot_z;
    logic signed [psrt_pkg::COORD_W-1:0] r_shift_x, r_shift_y, r_shift_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale   <= psrt_pkg::SCALE_RST;
            r_rot_x   <= psrt_pkg::ROT_RST;
            r_rot_y   <= psrt_pkg::ROT_RST;
            r_rot_z   <= psrt_pkg::ROT_RST;
            r_shift_x <= '0;
            r_shift_y <= '0;
            r_shift_z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                psrt_pkg::REG_SCALE:   r_scale   <= i_cfg_wdata;
                psrt_pkg::REG_ROT_X:   r_rot_x   <= i_cfg_wdata[psrt_pkg::ROT_W-1:0];
                psrt_pkg::REG_ROT_Y:   r_rot_y   <= i_cfg_wdata[psrt_pkg::ROT_W-1:0];
                psrt_pkg::REG_ROT_Z:   r_rot_z   <= i_cfg_wdata[psrt_pkg::ROT_W-1:0];
                psrt_pkg::REG_SHIFT_X: r_shift_x <= $signed(i_cfg_wdata[31:0]);
                psrt_pkg::REG_SHIFT_Y: r_shift_y <= $signed(i_cfg_wdata[31:0]);
                psrt_pkg::REG_SHIFT_Z: r_shift_z <= $signed(i_cfg_wdata[31:0]);
                default: ;  // unused index: write dropped
            endcase
        end
    end

    // Global advance: the chain moves unless a result is held at the output.
    logic           w_en;
    psrt_pkg::t_ctl w_in_ctl, w_sc_ctl, w_rx_ctl, w_ry_ctl, w_rz_ctl, w_out_ctl;

    assign w_en       = !(w_out_ctl.vld && i_out_stall);
    assign o_in_stall = !w_en;
    assign w_in_ctl   = '{vld: i_in_valid, clip: 1'b0};

    // scale -> p0..p2
    logic signed [psrt_pkg::COORD_W-1:0] w_p0, w_p1, w_p2;

    psrt_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_in_ctl),
        .i_x     (i_x_in),
        .i_y     (i_y_in),
        .i_z     (i_z_in),
        .i_scale (r_scale),
        .o_ctl   (w_sc_ctl),
        .o_x     (w_p0),
        .o_y     (w_p1),
        .o_z     (w_p2)
    );

    // about X: (y, z) rotate, x passes
    logic signed [psrt_pkg::COORD_W-1:0] w_q0, w_q1, w_q2;

    psrt_rot u_rot_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_sc_ctl),
        .i_a     (w_p1),
        .i_b     (w_p2),
        .i_p     (w_p0),
        .i_cs    (r_rot_x),
        .o_ctl   (w_rx_ctl),
        .o_a     (w_q1),
        .o_b     (w_q2),
        .o_p     (w_q0)
    );

    // about Y: (z, x) rotate, y passes
    logic signed [psrt_pkg::COORD_W-1:0] w_r0, w_r1, w_r2;

    psrt_rot u_rot_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_rx_ctl),
        .i_a     (w_q2),
        .i_b     (w_q0),
        .i_p     (w_q1),
        .i_cs    (r_rot_y),
        .o_ctl   (w_ry_ctl),
        .o_a     (w_r2),
        .o_b     (w_r0),
        .o_p     (w_r1)
    );

    // about Z: (x, y) rotate, z passes
    logic signed [psrt_pkg::COORD_W-1:0] w_s0, w_s1, w_s2;

    psrt_rot u_rot_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_ry_ctl),
        .i_a     (w_r0),
        .i_b     (w_r1),
        .i_p     (w_r2),
        .i_cs    (r_rot_z),
        .o_ctl   (w_rz_ctl),
        .o_a     (w_s0),
        .o_b     (w_s1),
        .o_p     (w_s2)
    );

    // translate into the output register
    psrt_xlate u_xlate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_rz_ctl),
        .i_x     (w_s0),
        .i_y     (w_s1),
        .i_z     (w_s2),
        .i_tx    (r_shift_x),
        .i_ty    (r_shift_y),
        .i_tz    (r_shift_z),
        .o_ctl   (w_out_ctl),
        .o_x     (o_x_out),
        .o_y     (o_y_out),
        .o_z     (o_z_out)
    );

    assign o_out_valid = w_out_ctl.vld;
    assign o_clipped   = w_out_ctl.clip;

endmodule

`default_nettype wire

### tb/tb_point_scale_rotate_translate_unit.sv
// Self-checking testbench for point_scale_rotate_translate_unit: directed extremes, then
// random points under random transforms, checked against an in-bench predictor.
// Depends on psrt_pkg and the RTL top level.
`default_nettype none

module tb_point_scale_rotate_translate_unit;

    // ------------------------------------------------------------------
    // Constants
    // ------------------------------------------------------------------
    localparam int          CLK_HALF      = 6;
    localparam int          RESET_CYCLES  = 11;
    localparam int          SETTLE_CYCLES = 12;      // pipeline is 9 deep
    localparam int          LONG_HOLD     = 150;     // forced receiver hold-off
    localparam int          N_PHASES      = 8;
    localparam int          PHASE_ITEMS   = 125;
    localparam longint      CYCLE_LIMIT   = 400000;
    localparam real         PI            = 3.14159265358979;
    localparam real         DEG_HALF_TURN = 180.0;

    localparam longint      Q_MAX = 64'sd2147483647;
    localparam longint      Q_MIN = -64'sd2147483648;

    localparam logic [psrt_pkg::COORD_W-1:0] PMAX = 32'h7FFF_FFFF;
    localparam logic [psrt_pkg::COORD_W-1:0] PMIN = 32'h8000_0000;
    localparam logic [psrt_pkg::COORD_W-1:0] NEG1 = 32'hFFFF_FFFF;

    // Index 7 is not decoded; writes to it must be dropped
    localparam logic [psrt_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

    // Directed transform settings
    localparam int SET_IDENT     = 0;
    localparam int SET_SCALE_MAX = 1;
    localparam int SET_SCALE_MIN = 2;
    localparam int SET_HALF      = 3;
    localparam int SET_ROT90     = 4;
    localparam int SET_TRIG_EXT  = 5;
    localparam int SET_SHIFT_MAX = 6;
    localparam int SET_SHIFT_MIN = 7;
    localparam int N_SETS        = 8;
    localparam int N_DIR         = 22;

    // ------------------------------------------------------------------
    // Types
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [psrt_pkg::SCALE_W-1:0] scale;
        logic [psrt_pkg::ROT_W-1:0]   rot_x;
        logic [psrt_pkg::ROT_W-1:0]   rot_y;
        logic [psrt_pkg::ROT_W-1:0]   rot_z;
        logic [psrt_pkg::COORD_W-1:0] shift_x;
        logic [psrt_pkg::COORD_W-1:0] shift_y;
        logic [psrt_pkg::COORD_W-1:0] shift_z;
    } t_xform_cfg;

    typedef struct packed {
        logic [psrt_pkg::COORD_W-1:0] x;
        logic [psrt_pkg::COORD_W-1:0] y;
        logic [psrt_pkg::COORD_W-1:0] z;
        logic                         clipped;
    } t_point_result;

    // One directed request; 'known' rows carry a hand-derived result,
    // the rest go through transform_point()
    typedef struct packed {
        int                           set_id;
        bit                           known;
        logic [psrt_pkg::COORD_W-1:0] x;
        logic [psrt_pkg::COORD_W-1:0] y;
        logic [psrt_pkg::COORD_W-1:0] z;
        t_point_result                want;
    } t_dir_row;

    localparam t_point_result COMPUTED = '0;

    localparam t_xform_cfg DIR_SETS [0:N_SETS-1] = '{
        '{48'h0100_0100_0100, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h0, 32'h0, 32'h0},
        '{48'h7FFF_7FFF_7FFF, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h0, 32'h0, 32'h0},
        '{48'h8000_8000_8000, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h0, 32'h0, 32'h0},
        '{48'h0080_0080_0080, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h0, 32'h0, 32'h0},
        '{48'h0100_0100_0100, 32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 32'h0, 32'h0, 32'h0},
        '{48'h0100_0100_0100, 32'h7FFF_8000, 32'h8000_7FFF, 32'h8000_8000, 32'h0, 32'h0, 32'h0},
        '{48'h0100_0100_0100, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000, PMAX, PMAX, PMAX},
        '{48'h0100_0100_0100, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000, PMIN, PMIN, PMIN}
    };

    localparam t_dir_row DIR_ROWS [0:N_DIR-1] = '{
        // after reset the transform is the identity: the point comes back as is
        '{SET_IDENT, 1'b1, 32'h0, 32'h0, 32'h0, '{32'h0, 32'h0, 32'h0, 1'b0}},
        '{SET_IDENT, 1'b1, PMAX, PMIN, 32'h1, '{PMAX, PMIN, 32'h1, 1'b0}},
        '{SET_IDENT, 1'b1, PMIN, PMAX, NEG1, '{PMIN, PMAX, NEG1, 1'b0}},
        '{SET_IDENT, 1'b1, 32'h1234_5678, 32'hEDCB_A988, 32'h0001_0000,
          '{32'h1234_5678, 32'hEDCB_A988, 32'h0001_0000, 1'b0}},
        // largest scale: full-range inputs clamp in the scale stage
        '{SET_SCALE_MAX, 1'b1, PMAX, PMAX, PMAX, '{PMAX, PMAX, PMAX, 1'b1}},
        '{SET_SCALE_MAX, 1'b1, PMIN, PMIN, PMIN, '{PMIN, PMIN, PMIN, 1'b1}},
        '{SET_SCALE_MAX, 1'b0, 32'h0001_0000, NEG1, 32'h0000_0100, COMPUTED},
        // scale -128.0 flips the sign and clamps
        '{SET_SCALE_MIN, 1'b1, PMIN, PMIN, PMIN, '{PMAX, PMAX, PMAX, 1'b1}},
        '{SET_SCALE_MIN, 1'b1, PMAX, PMAX, PMAX, '{PMIN, PMIN, PMIN, 1'b1}},
        '{SET_SCALE_MIN, 1'b0, 32'h0000_0100, 32'hFFFF_FF00, 32'h0000_8000, COMPUTED},
        // scale 0.5: half-LSB results round toward +infinity
        '{SET_HALF, 1'b1, 32'h1, NEG1, 32'h3, '{32'h1, 32'h0, 32'h2, 1'b0}},
        '{SET_HALF, 1'b0, 32'h0000_0101, PMIN, PMAX, COMPUTED},
        // 90 degrees about every axis
        '{SET_ROT90, 1'b0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, COMPUTED},
        '{SET_ROT90, 1'b0, PMAX, PMIN, PMAX, COMPUTED},
        '{SET_ROT90, 1'b0, 32'h1, 32'h2, 32'h3, COMPUTED},
        // trig pairs far outside the unit circle are used as is
        '{SET_TRIG_EXT, 1'b0, PMAX, PMAX, PMAX, COMPUTED},
        '{SET_TRIG_EXT, 1'b0, PMIN, PMIN, PMIN, COMPUTED},
        '{SET_TRIG_EXT, 1'b0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, COMPUTED},
        // translation clamps on its own
        '{SET_SHIFT_MAX, 1'b1, PMAX, 32'h0, 32'h0, '{PMAX, PMAX, PMAX, 1'b1}},
        '{SET_SHIFT_MAX, 1'b1, PMIN, PMIN, PMIN, '{NEG1, NEG1, NEG1, 1'b0}},
        '{SET_SHIFT_MIN, 1'b1, PMIN, 32'h0, 32'h0, '{PMIN, PMIN, PMIN, 1'b1}},
        '{SET_SHIFT_MIN, 1'b1, PMAX, PMAX, PMAX, '{NEG1, NEG1, NEG1, 1'b0}}
    };

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_cfg_we    = 1'b0;
    logic [psrt_pkg::IDX_W-1:0]           i_cfg_idx   = '0;
    logic [psrt_pkg::CFG_W-1:0]           i_cfg_wdata = '0;
    logic                                 i_in_valid  = 1'b0;
    logic                                 o_in_stall;
    logic signed [psrt_pkg::COORD_W-1:0]  i_x_in      = '0;
    logic signed [psrt_pkg::COORD_W-1:0]  i_y_in      = '0;
    logic signed [psrt_pkg::COORD_W-1:0]  i_z_in      = '0;
    logic                                 o_out_valid;
    logic                                 i_out_stall = 1'b0;
    logic signed [psrt_pkg::COORD_W-1:0]  o_x_out;
    logic signed [psrt_pkg::COORD_W-1:0]  o_y_out;
    logic signed [psrt_pkg::COORD_W-1:0]  o_z_out;
    logic                                 o_clipped;

    point_scale_rotate_translate_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_x_in      (i_x_in),
        .i_y_in      (i_y_in),
        .i_z_in      (i_z_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_x_out     (o_x_out),
        .o_y_out     (o_y_out),
        .o_z_out     (o_z_out),
        .o_clipped   (o_clipped)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_xform_cfg     live_cfg = DIR_SETS[SET_IDENT];   // mirror of the DUT registers
    t_point_result  pending_points [$];               // expected results, oldest first
    int             n_errors   = 0;
    longint         cycle_cnt  = 0;
    int unsigned    burst_left = 0;
    bit             hold_req   = 1'b0;                // ask the receiver for a long hold-off
    bit             pred_clip;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // floor((v + 2^(n-1)) / 2^n): round half toward +infinity
    function automatic longint round_shr(input longint v, input int unsigned n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clamp_q16(input longint v);
        if (v > Q_MAX) begin
            pred_clip = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            pred_clip = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    // one rotation output: c0*v0 + c1*v1, Q2.14 coefficients, back to Q16.16
    function automatic longint rot_sum(input longint c0, input longint v0,
                                       input longint c1, input longint v1);
        return clamp_q16(round_shr(c0 * v0 + c1 * v1, psrt_pkg::ROT_FRAC));
    endfunction

    // Rz*Ry*Rx*S*p + t under the current register mirror
    function automatic t_point_result transform_point(
        input logic [psrt_pkg::COORD_W-1:0] xi,
        input logic [psrt_pkg::COORD_W-1:0] yi,
        input logic [psrt_pkg::COORD_W-1:0] zi);
        t_point_result r;
        longint p0, p1, p2, q0, q1, q2, c, s, t;
        pred_clip = 1'b0;

        p0 = clamp_q16(round_shr(longint'($signed(xi)) *
                                 longint'($signed(live_cfg.scale[47:32])),
                                 psrt_pkg::SCALE_FRAC));
        p1 = clamp_q16(round_shr(longint'($signed(yi)) *
                                 longint'($signed(live_cfg.scale[31:16])),
                                 psrt_pkg::SCALE_FRAC));
        p2 = clamp_q16(round_shr(longint'($signed(zi)) *
                                 longint'($signed(live_cfg.scale[15:0])),
                                 psrt_pkg::SCALE_FRAC));

        // about X
        c  = longint'($signed(live_cfg.rot_x[31:16]));
        s  = longint'($signed(live_cfg.rot_x[15:0]));
        q0 = p0;
        q1 = rot_sum(c, p1, -s, p2);
        q2 = rot_sum(s, p1, c, p2);

        // about Y
        c  = longint'($signed(live_cfg.rot_y[31:16]));
        s  = longint'($signed(live_cfg.rot_y[15:0]));
        p0 = rot_sum(c, q0, s, q2);
        p1 = q1;
        p2 = rot_sum(-s, q0, c, q2);

        // about Z
        c  = longint'($signed(live_cfg.rot_z[31:16]));
        s  = longint'($signed(live_cfg.rot_z[15:0]));
        q0 = rot_sum(c, p0, -s, p1);
        q1 = rot_sum(s, p0, c, p1);
        q2 = p2;

        t = clamp_q16(q0 + longint'($signed(live_cfg.shift_x)));
        r.x = t[psrt_pkg::COORD_W-1:0];
        t = clamp_q16(q1 + longint'($signed(live_cfg.shift_y)));
        r.y = t[psrt_pkg::COORD_W-1:0];
        t = clamp_q16(q2 + longint'($signed(live_cfg.shift_z)));
        r.z = t[psrt_pkg::COORD_W-1:0];
        r.clipped = pred_clip;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random values
    // ------------------------------------------------------------------
    function automatic logic [psrt_pkg::COEF_W-1:0] random_scale();
        int v;
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom);
            default: begin
                v = int'($urandom_range(0, 1024)) - 512;   // within +-2.0
                return v[psrt_pkg::COEF_W-1:0];
            end
        endcase
    endfunction

    // mostly a real angle, now and then any bit pattern
    function automatic logic [psrt_pkg::ROT_W-1:0] random_trig();
        real rad;
        int  c, s;
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        rad = real'($urandom_range(0, 35999)) / 100.0 * PI / DEG_HALF_TURN;
        c = int'($cos(rad) * real'(1 << psrt_pkg::ROT_FRAC));
        s = int'($sin(rad) * real'(1 << psrt_pkg::ROT_FRAC));
        return {c[psrt_pkg::COEF_W-1:0], s[psrt_pkg::COEF_W-1:0]};
    endfunction

    function automatic logic [psrt_pkg::COORD_W-1:0] random_shift();
        int v;
        if ($urandom_range(0, 9) < 3)
            return $urandom;
        v = int'($urandom_range(0, 1 << 21)) - (1 << 20);
        return v;
    endfunction

    function automatic logic [psrt_pkg::COORD_W-1:0] random_coord();
        int v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return PMAX;
                    1: return PMIN;
                    2: return 32'h0;
                    3: return 32'h1;
                    default: return NEG1;
                endcase
            end
            1, 2, 3: return $urandom;
            default: begin
                v = int'($urandom_range(0, 1 << 25)) - (1 << 24);   // within +-256.0
                return v;
            end
        endcase
    endfunction

    function automatic t_xform_cfg random_settings();
        t_xform_cfg c;
        c.scale   = {random_scale(), random_scale(), random_scale()};
        c.rot_x   = random_trig();
        c.rot_y   = random_trig();
        c.rot_z   = random_trig();
        c.shift_x = random_shift();
        c.shift_y = random_shift();
        c.shift_z = random_shift();
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Configuration writes (pipeline must be empty)
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [psrt_pkg::IDX_W-1:0] idx,
                             input logic [psrt_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // 32-bit registers get junk in the unused upper data bits; the block
    // must drop it, as it must drop the write to the undecoded index
    task automatic apply_settings(input t_xform_cfg c);
        write_reg(psrt_pkg::REG_SCALE,   c.scale);
        write_reg(psrt_pkg::REG_ROT_X,   {16'($urandom), c.rot_x});
        write_reg(psrt_pkg::REG_ROT_Y,   {16'($urandom), c.rot_y});
        write_reg(psrt_pkg::REG_ROT_Z,   {16'($urandom), c.rot_z});
        write_reg(REG_UNUSED,            {16'($urandom), 32'($urandom)});
        write_reg(psrt_pkg::REG_SHIFT_X, {16'($urandom), c.shift_x});
        write_reg(psrt_pkg::REG_SHIFT_Y, {16'($urandom), c.shift_y});
        write_reg(psrt_pkg::REG_SHIFT_Z, {16'($urandom), c.shift_z});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        live_cfg = c;
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Offer one request and hold it until taken. Requests go out in bursts
    // of random length; a burst ends in a random gap (sometimes none).
    task automatic send_point(input logic [psrt_pkg::COORD_W-1:0] x,
                              input logic [psrt_pkg::COORD_W-1:0] y,
                              input logic [psrt_pkg::COORD_W-1:0] z, input bit known,
                              input t_point_result want);
        int unsigned gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_x_in     <= x;
        i_y_in     <= y;
        i_z_in     <= z;
        do @(posedge i_clk); while (o_in_stall);
        pending_points.push_back(known ? want : transform_point(x, y, z));

        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
    endtask

    // Stop offering, wait for every outstanding result, then let the
    // pipeline run dry before anything else happens.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern
    // ------------------------------------------------------------------
    // Stall probability changes every span; some spans never stall. A long
    // hold-off comes on request and now and then on its own, so the whole
    // pipeline backs up into o_in_stall.
    int unsigned hold_left = 0;
    int unsigned span_left = 0;
    int unsigned stall_pct = 0;

    always @(negedge i_clk) begin
        if (hold_left == 0 && hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (span_left == 0) begin
                span_left = $urandom_range(16, 200);
                case ($urandom_range(0, 5))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 10;
                    3: stall_pct = 40;
                    4: stall_pct = 80;
                    default: begin
                        stall_pct = 0;
                        hold_left = $urandom_range(30, 100);
                    end
                endcase
            end
            span_left--;
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_point_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_points.size() == 0) begin
                $error("result with no request outstanding: x_out %h y_out %h z_out %h",
                       o_x_out, o_y_out, o_z_out);
                n_errors++;
            end else begin
                want = pending_points.pop_front();
                if (o_x_out !== want.x) begin
                    $error("x_out: expected %h, got %h", want.x, o_x_out);
                    n_errors++;
                end
                if (o_y_out !== want.y) begin
                    $error("y_out: expected %h, got %h", want.y, o_y_out);
                    n_errors++;
                end
                if (o_z_out !== want.z) begin
                    $error("z_out: expected %h, got %h", want.z, o_z_out);
                    n_errors++;
                end
                if (o_clipped !== want.clipped) begin
                    $error("clipped: expected %b, got %b", want.clipped, o_clipped);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int cur_set;
        cur_set = SET_IDENT;   // reset state equals the identity setting

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: first rows run on reset values, no writes yet
        for (int i = 0; i < N_DIR; i++) begin
            if (DIR_ROWS[i].set_id != cur_set) begin
                settle();
                cur_set = DIR_ROWS[i].set_id;
                apply_settings(DIR_SETS[cur_set]);
            end
            send_point(DIR_ROWS[i].x, DIR_ROWS[i].y, DIR_ROWS[i].z,
                       DIR_ROWS[i].known, DIR_ROWS[i].want);
        end

        // Random: a fresh transform per phase; the first phase opens
        // with a long receiver hold-off while requests keep coming
        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            apply_settings(random_settings());
            if (ph == 0)
                hold_req = 1'b1;
            repeat (PHASE_ITEMS)
                send_point(random_coord(), random_coord(), random_coord(), 1'b0, COMPUTED);
        end

        settle();
        if (pending_points.size() != 0)
            n_errors++;
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
